[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rsd_pkg.sv]
// ----------------------------------------------------------------------------
// rsd_pkg
// Types, constants and the control store of the descending record sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int KEY_W           = 24;
    localparam int TAG_W           = 32;

    // One stored record: key and the tag that travels with it
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    // Step addresses of the control program
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_LD_HOLD,
        ST_RD_J,
        ST_CMP,
        ST_EMIT
    } t_step;

    // Branch and wait conditions
    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_LAST_IN,
        CND_J_END,
        CND_OUT_BUSY,
        CND_LAST_OUT
    } t_cond;

    // Store read address select
    typedef enum logic [1:0] {
        RA_NONE,
        RA_I,
        RA_J
    } t_rdsel;

    // One control word
    typedef struct packed {
        logic   in_rdy;
        t_rdsel rd_sel;
        logic   set_j;
        logic   load_hold;
        logic   cmp_swap;
        logic   emit;
        t_cond  wait_cond;
        t_cond  br_cond;
        t_step  br_tgt;
        t_step  seq_tgt;
    } t_uword;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic last_in;
        logic j_end;
        logic out_busy;
        logic last_out;
    } t_flags;

    // Control program
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{in_rdy: 1'b0, rd_sel: RA_NONE, set_j: 1'b0, load_hold: 1'b0,
              cmp_swap: 1'b0, emit: 1'b0, wait_cond: CND_NEVER,
              br_cond: CND_NEVER, br_tgt: ST_LOAD, seq_tgt: ST_LOAD};
        unique case (s)
            ST_LOAD: begin
                w.in_rdy  = 1'b1;
                w.br_cond = CND_LAST_IN;
                w.br_tgt  = ST_RD_I;
                w.seq_tgt = ST_LOAD;
            end
            ST_RD_I: begin
                w.rd_sel  = RA_I;
                w.set_j   = 1'b1;
                w.seq_tgt = ST_LD_HOLD;
            end
            ST_LD_HOLD: begin
                w.load_hold = 1'b1;
                w.seq_tgt   = ST_RD_J;
            end
            ST_RD_J: begin
                w.rd_sel  = RA_J;
                w.br_cond = CND_J_END;
                w.br_tgt  = ST_EMIT;
                w.seq_tgt = ST_CMP;
            end
            ST_CMP: begin
                w.cmp_swap = 1'b1;
                w.seq_tgt  = ST_RD_J;
            end
            ST_EMIT: begin
                w.emit      = 1'b1;
                w.wait_cond = CND_OUT_BUSY;
                w.br_cond   = CND_LAST_OUT;
                w.br_tgt    = ST_LOAD;
                w.seq_tgt   = ST_RD_I;
            end
            default: begin
                w.seq_tgt = ST_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[design/rsd_in_if.sv]
// ----------------------------------------------------------------------------
// rsd_in_if
// Input channel: one record per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsd_in_if;
    logic                     valid;
    logic                     ready;
    logic [rsd_pkg::KEY_W-1:0] step_count;
    logic [rsd_pkg::TAG_W-1:0] record_tag;
    logic                     last_record;

    modport source (output valid, output step_count, output record_tag,
                    output last_record, input ready);
    modport sink   (input valid, input step_count, input record_tag,
                    input last_record, output ready);
endinterface

`default_nettype wire

[design/rsd_out_if.sv]
// ----------------------------------------------------------------------------
// rsd_out_if
// Output channel: one sorted record per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsd_out_if;
    logic                     valid;
    logic                     ready;
    logic [rsd_pkg::KEY_W-1:0] sorted_count;
    logic [rsd_pkg::TAG_W-1:0] sorted_tag;
    logic                     final_result;

    modport source (output valid, output sorted_count, output sorted_tag,
                    output final_result, input ready);
    modport sink   (input valid, input sorted_count, input sorted_tag,
                    input final_result, output ready);
endinterface

`default_nettype wire

[design/rsd_store.sv]
// ----------------------------------------------------------------------------
// rsd_store
// Record store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_store #(
    parameter int DEPTH = rsd_pkg::MAX_RECORDS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire rsd_pkg::t_rec            i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output rsd_pkg::t_rec                 o_rdata
);

    rsd_pkg::t_rec r_mem [DEPTH];
    rsd_pkg::t_rec r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/rsd_useq.sv]
// ----------------------------------------------------------------------------
// rsd_useq
// Control sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_useq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rsd_pkg::t_flags  i_flags,
    output rsd_pkg::t_uword       o_uword
);

    rsd_pkg::t_step  r_step;
    rsd_pkg::t_step  n_step;
    rsd_pkg::t_uword uw;

    function automatic logic cond_true(input rsd_pkg::t_cond c,
                                       input rsd_pkg::t_flags f);
        logic r;
        unique case (c)
            rsd_pkg::CND_NEVER:    r = 1'b0;
            rsd_pkg::CND_ALWAYS:   r = 1'b1;
            rsd_pkg::CND_LAST_IN:  r = f.last_in;
            rsd_pkg::CND_J_END:    r = f.j_end;
            rsd_pkg::CND_OUT_BUSY: r = f.out_busy;
            rsd_pkg::CND_LAST_OUT: r = f.last_out;
            default:               r = 1'b0;
        endcase
        return r;
    endfunction

    // Control word of the current step
    always_comb begin
        uw = rsd_pkg::ucode(r_step);
    end

    assign o_uword = uw;

    // Next step: wait, branch, or fall through
    always_comb begin
        priority if (cond_true(uw.wait_cond, i_flags)) begin
            n_step = r_step;
        end else if (cond_true(uw.br_cond, i_flags)) begin
            n_step = uw.br_tgt;
        end else begin
            n_step = uw.seq_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rsd_pkg::ST_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

[design/record_sort_descending.sv]
// Loading: one record per cycle; a record beyond MAX_RECORDS is dropped.
// Sorting n records: pass i reads record i into the holding register, then reads
// each later record and compares it, one read per compare on the single read port.
// Pass i ends by handing the largest remaining record to the output register,
// waiting while the output register holds an item not yet taken.
// Synchronous active-low reset clears the sequencer, counters and output valid.
// ----------------------------------------------------------------------------
// record_sort_descending
// Stores records until one marked last, runs an exchange sort held in a
// microprogram, and emits the records in descending key order.
// ----------------------------------------------------------------------------
`default_nettype none

module record_sort_descending #(
    parameter int MAX_RECORDS = rsd_pkg::MAX_RECORDS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rsd_in_if.sink     i_rec,
    rsd_out_if.source  o_srt
);

    localparam int AW    = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    rsd_pkg::t_uword uw;
    rsd_pkg::t_flags flags;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    rsd_pkg::t_rec    r_hold;
    rsd_pkg::t_rec    r_out;
    logic             r_out_final;
    logic             r_out_valid;

    rsd_pkg::t_rec    rd_data;
    rsd_pkg::t_rec    in_rec;
    rsd_pkg::t_rec    wr_data;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;

    logic in_acc;
    logic not_full;
    logic swap;
    logic out_busy;
    logic last_out;
    logic emit_fire;

    // Sequencer
    rsd_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    // Handshake and status
    assign i_rec.ready = uw.in_rdy;
    assign in_acc      = i_rec.valid && uw.in_rdy;
    assign not_full    = (r_cnt < CNT_W'(MAX_RECORDS));
    assign swap        = uw.cmp_swap && (r_hold.key < rd_data.key);
    assign out_busy    = r_out_valid && !o_srt.ready;
    assign last_out    = (CNT_W'(r_i + 1'b1) == r_cnt);
    assign emit_fire   = uw.emit && !out_busy;

    always_comb begin
        flags.last_in  = in_acc && i_rec.last_record;
        flags.j_end    = (r_j >= r_cnt);
        flags.out_busy = out_busy;
        flags.last_out = last_out;
    end

    // Store write port: loading or the swap of a compare
    always_comb begin
        in_rec.key = i_rec.step_count;
        in_rec.tag = i_rec.record_tag;
        if (swap) begin
            wr_en   = 1'b1;
            wr_addr = r_j[AW-1:0];
            wr_data = r_hold;
        end else begin
            wr_en   = in_acc && not_full;
            wr_addr = r_cnt[AW-1:0];
            wr_data = in_rec;
        end
    end

    // Store read port
    always_comb begin
        unique case (uw.rd_sel)
            rsd_pkg::RA_I: begin
                rd_en   = 1'b1;
                rd_addr = r_i[AW-1:0];
            end
            rsd_pkg::RA_J: begin
                rd_en   = 1'b1;
                rd_addr = r_j[AW-1:0];
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = r_i[AW-1:0];
            end
        endcase
    end

    rsd_store #(
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Record count and pass index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_i   <= '0;
        end else begin
            if (in_acc && not_full) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end
            if (in_acc && i_rec.last_record) begin
                r_i <= '0;
            end
            if (emit_fire) begin
                if (last_out) begin
                    r_cnt <= '0;
                end else begin
                    r_i <= CNT_W'(r_i + 1'b1);
                end
            end
        end
    end

    // Inner index: starts after i, steps on every compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
        end else if (uw.set_j) begin
            r_j <= CNT_W'(r_i + 1'b1);
        end else if (uw.cmp_swap) begin
            r_j <= CNT_W'(r_j + 1'b1);
        end
    end

    // Holding register: the running maximum of the current pass
    always_ff @(posedge i_clk) begin
        if (uw.load_hold || swap) begin
            r_hold <= rd_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_srt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out       <= r_hold;
            r_out_final <= last_out;
        end
    end

    assign o_srt.valid        = r_out_valid;
    assign o_srt.sorted_count = r_out.key;
    assign o_srt.sorted_tag   = r_out.tag;
    assign o_srt.final_result = r_out_final;

endmodule

`default_nettype wire

[design/rsd_checker.sv]
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks of the record sorter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rsd_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_last,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_final
);

    // A waiting result item stays offered
    `RSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result item withdrawn before taken")

    // The last record of a set closes the input while the sort runs
    `RSD_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, !i_in_ready, "input open right after last record")

    // Loading reopens only once the final result item is in the output register
    `RSD_ASSERT_IMPL(a_load_after_final, i_clk, i_rst_n, i_in_ready && i_out_valid, i_out_final, "input open while a non-final result waits")

    // No result item appears in the cycle after a non-last record is taken
    `RSD_ASSERT_NEXT(a_no_early_out, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_in_last && !i_out_valid, !i_out_valid, "result item appeared during loading")

endmodule

bind record_sort_descending rsd_checker u_rsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rec.valid),
    .i_in_ready  (i_rec.ready),
    .i_in_last   (i_rec.last_record),
    .i_out_valid (o_srt.valid),
    .i_out_ready (o_srt.ready),
    .i_out_final (o_srt.final_result)
);

`default_nettype wire
